/* src/fcvs_pkg.sv */
// Shared types, constants and register codes of the fused corner voltage setpoint block.
package fcvs_pkg;

    localparam int FUSE_W      = 64;
    localparam int UV_W        = 21;
    localparam int UNDERVOLT_W = 7;
    localparam int FREQ_W      = 12;
    localparam int RANGE_W     = 8;
    localparam int VLEVEL_W    = 8;
    localparam int CORNER_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CORNERS = 3;
    localparam int TRIM_W      = 6;
    localparam int WANT_W      = 23;

    localparam int MAX_UNDERVOLT_STEPS_DEF = 40;

    localparam int TRIM_LSB1 = 0;
    localparam int TRIM_LSB2 = 18;
    localparam int TRIM_LSB3 = 36;

    localparam logic [UV_W-1:0] TRIM_STEP_UV  = 21'd10000;
    localparam logic [UV_W-1:0] RAIL_STEP_UV  = 21'd12500;
    localparam logic [UV_W-1:0] RAIL_MIN_UV   = 21'd375000;
    localparam logic [UV_W-1:0] RAIL_MAX_UV   = 21'd1562500;
    localparam logic [UV_W-1:0] HARD_FLOOR_UV = 21'd550000;

    localparam logic signed [WANT_W-1:0] RAIL_STEP_UV_S = 23'sd12500;

    localparam logic [FREQ_W-1:0] CORNER1_MAX_MHZ = 12'd400;
    localparam logic [FREQ_W-1:0] CORNER2_MAX_MHZ = 12'd800;

    localparam logic [UV_W-1:0] CEIL1_RST  = 21'd1050000;
    localparam logic [UV_W-1:0] CEIL2_RST  = 21'd1225000;
    localparam logic [UV_W-1:0] CEIL3_RST  = 21'd1350000;
    localparam logic [UV_W-1:0] FLOOR1_RST = 21'd1050000;
    localparam logic [UV_W-1:0] FLOOR2_RST = 21'd1050000;
    localparam logic [UV_W-1:0] FLOOR3_RST = 21'd1155000;

    // floor(y / 3125) = (y * RECIP_MULT) >> RECIP_SHIFT, exact for y below 2^19
    localparam int              QDIV_W      = 19;
    localparam int              RECIP_W     = 18;
    localparam int              RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd171799;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FUSE_ROW,
        REG_UNDERVOLT,
        REG_CEIL1,
        REG_CEIL2,
        REG_CEIL3,
        REG_FLOOR1,
        REG_FLOOR2,
        REG_FLOOR3
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_RANGE,
        STATUS_REGULATOR
    } status_t;

    typedef struct packed {
        logic [FUSE_W-1:0]                   fuse_row;
        logic signed [UNDERVOLT_W-1:0]       undervolt;
        logic [NUM_CORNERS-1:0][UV_W-1:0]    ceiling_uv;
        logic [NUM_CORNERS-1:0][UV_W-1:0]    floor_uv;
    } cfg_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  frequency_mhz;
        logic [RANGE_W-1:0] regulator_range;
    } item_t;

    typedef struct packed {
        logic [UV_W-1:0]     want_uv;
        status_t             status;
        logic [CORNER_W-1:0] corner;
        logic                fuse_valid;
    } want_t;

    typedef struct packed {
        logic load_want;
        logic load_quot;
        logic load_out;
    } stage_ctrl_t;

endpackage

/* src/fcvs_cfg.sv */
// Configuration registers with saturation of the undervolt offset.
module fcvs_cfg #(
    parameter int MAX_UNDERVOLT_STEPS = fcvs_pkg::MAX_UNDERVOLT_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fcvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcvs_pkg::FUSE_W-1:0]    cfg_wdata,
    output fcvs_pkg::cfg_t                 cfg
);

    fcvs_pkg::cfg_t                          cfg_reg;
    fcvs_pkg::cfg_t                          cfg_next;
    int                                      uv_raw;
    logic signed [fcvs_pkg::UNDERVOLT_W-1:0] uv_sat;
    logic [fcvs_pkg::UV_W-1:0]               wdata_uv;

    always_comb
    begin
        uv_raw = int'($signed(cfg_wdata[fcvs_pkg::UNDERVOLT_W-1:0]));
        if (uv_raw > 0)
        begin
            uv_raw = 0;
        end
        if (uv_raw < -MAX_UNDERVOLT_STEPS)
        begin
            uv_raw = -MAX_UNDERVOLT_STEPS;
        end
        uv_sat = fcvs_pkg::UNDERVOLT_W'(uv_raw);
    end

    assign wdata_uv = cfg_wdata[fcvs_pkg::UV_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (fcvs_pkg::reg_index_t'(cfg_index))
                fcvs_pkg::REG_FUSE_ROW:  cfg_next.fuse_row      = cfg_wdata;
                fcvs_pkg::REG_UNDERVOLT: cfg_next.undervolt     = uv_sat;
                fcvs_pkg::REG_CEIL1:     cfg_next.ceiling_uv[0] = wdata_uv;
                fcvs_pkg::REG_CEIL2:     cfg_next.ceiling_uv[1] = wdata_uv;
                fcvs_pkg::REG_CEIL3:     cfg_next.ceiling_uv[2] = wdata_uv;
                fcvs_pkg::REG_FLOOR1:    cfg_next.floor_uv[0]   = wdata_uv;
                fcvs_pkg::REG_FLOOR2:    cfg_next.floor_uv[1]   = wdata_uv;
                fcvs_pkg::REG_FLOOR3:    cfg_next.floor_uv[2]   = wdata_uv;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fuse_row      <= '0;
            cfg_reg.undervolt     <= '0;
            cfg_reg.ceiling_uv[0] <= fcvs_pkg::CEIL1_RST;
            cfg_reg.ceiling_uv[1] <= fcvs_pkg::CEIL2_RST;
            cfg_reg.ceiling_uv[2] <= fcvs_pkg::CEIL3_RST;
            cfg_reg.floor_uv[0]   <= fcvs_pkg::FLOOR1_RST;
            cfg_reg.floor_uv[1]   <= fcvs_pkg::FLOOR2_RST;
            cfg_reg.floor_uv[2]   <= fcvs_pkg::FLOOR3_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/fcvs_want.sv */
// Corner decode, fuse trim, clamps, undervolt offset and range check.
module fcvs_want (
    input  logic            clk,
    input  logic            load,
    input  fcvs_pkg::item_t item,
    input  fcvs_pkg::cfg_t  cfg,
    output fcvs_pkg::want_t want
);

    fcvs_pkg::want_t                    want_reg;
    fcvs_pkg::want_t                    want_next;
    logic [1:0]                         cidx;
    logic [fcvs_pkg::TRIM_W-1:0]        trim;
    logic [fcvs_pkg::UV_W-1:0]          ceil_sel;
    logic [fcvs_pkg::UV_W-1:0]          floor_sel;
    logic [fcvs_pkg::QDIV_W-1:0]        delta;
    logic                               fuse_ok;
    logic signed [fcvs_pkg::WANT_W-1:0] trimmed;
    logic signed [fcvs_pkg::WANT_W-1:0] corner_uv;
    logic signed [fcvs_pkg::WANT_W-1:0] sum;

    assign fuse_ok = (cfg.fuse_row != '0) && (cfg.fuse_row != '1);

    always_comb
    begin
        if (item.frequency_mhz <= fcvs_pkg::CORNER1_MAX_MHZ)
        begin
            cidx = 2'd0;
        end
        else if (item.frequency_mhz <= fcvs_pkg::CORNER2_MAX_MHZ)
        begin
            cidx = 2'd1;
        end
        else
        begin
            cidx = 2'd2;
        end

        case (cidx)
            2'd0:    trim = cfg.fuse_row[fcvs_pkg::TRIM_LSB1 +: fcvs_pkg::TRIM_W];
            2'd1:    trim = cfg.fuse_row[fcvs_pkg::TRIM_LSB2 +: fcvs_pkg::TRIM_W];
            default: trim = cfg.fuse_row[fcvs_pkg::TRIM_LSB3 +: fcvs_pkg::TRIM_W];
        endcase

        ceil_sel  = cfg.ceiling_uv[cidx];
        floor_sel = cfg.floor_uv[cidx];
        delta     = fcvs_pkg::QDIV_W'(trim[fcvs_pkg::TRIM_W-2:0] * fcvs_pkg::TRIM_STEP_UV);

        // raise steps never exceed the ceiling; lower steps then meet the floor
        if (trim[fcvs_pkg::TRIM_W-1])
        begin
            trimmed = $signed({2'b00, ceil_sel}) - $signed({4'b0000, delta});
        end
        else
        begin
            trimmed = $signed({2'b00, ceil_sel});
        end
        if (trimmed < $signed({2'b00, floor_sel}))
        begin
            trimmed = $signed({2'b00, floor_sel});
        end

        corner_uv = fuse_ok ? trimmed : $signed({2'b00, ceil_sel});
        sum = corner_uv + fcvs_pkg::WANT_W'(cfg.undervolt) * fcvs_pkg::RAIL_STEP_UV_S;
        if (sum < $signed({2'b00, fcvs_pkg::HARD_FLOOR_UV}))
        begin
            sum = $signed({2'b00, fcvs_pkg::HARD_FLOOR_UV});
        end

        want_next.want_uv    = sum[fcvs_pkg::UV_W-1:0];
        want_next.corner     = 2'(cidx + 2'd1);
        want_next.fuse_valid = fuse_ok;
        if (sum > $signed({2'b00, fcvs_pkg::RAIL_MAX_UV}))
        begin
            want_next.status = fcvs_pkg::STATUS_RANGE;
        end
        else if (item.regulator_range != '0)
        begin
            want_next.status = fcvs_pkg::STATUS_REGULATOR;
        end
        else
        begin
            want_next.status = fcvs_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            want_reg <= want_next;
        end
    end

    assign want = want_reg;

endmodule

/* src/fcvs_enc.sv */
// Round-up setpoint code by reciprocal multiply, then the programmed voltage.
module fcvs_enc (
    input  logic                          clk,
    input  fcvs_pkg::stage_ctrl_t         ctrl,
    input  fcvs_pkg::want_t               want,
    output logic [1:0]                    status,
    output logic [fcvs_pkg::VLEVEL_W-1:0] vlevel,
    output logic [fcvs_pkg::UV_W-1:0]     programmed_uv,
    output logic [fcvs_pkg::CORNER_W-1:0] corner,
    output logic                          fuse_valid
);

    localparam int PROD_W = fcvs_pkg::QDIV_W + fcvs_pkg::RECIP_W;

    typedef struct packed {
        fcvs_pkg::status_t             status;
        logic [fcvs_pkg::VLEVEL_W-1:0] vlevel;
        logic [fcvs_pkg::CORNER_W-1:0] corner;
        logic                          fuse_valid;
    } quot_t;

    typedef struct packed {
        fcvs_pkg::status_t             status;
        logic [fcvs_pkg::VLEVEL_W-1:0] vlevel;
        logic [fcvs_pkg::UV_W-1:0]     programmed_uv;
        logic [fcvs_pkg::CORNER_W-1:0] corner;
        logic                          fuse_valid;
    } result_t;

    quot_t                       quot_reg;
    quot_t                       quot_next;
    result_t                     result_reg;
    result_t                     result_next;
    logic [fcvs_pkg::UV_W-1:0]   offset_uv;
    logic [PROD_W-1:0]           prod;

    // want is at least the hard floor, so the offset never wraps
    assign offset_uv = fcvs_pkg::UV_W'(want.want_uv - fcvs_pkg::RAIL_MIN_UV
                                       + fcvs_pkg::RAIL_STEP_UV - 21'd1);
    assign prod      = PROD_W'(offset_uv[fcvs_pkg::UV_W-1:2]) * PROD_W'(fcvs_pkg::RECIP_MULT);

    always_comb
    begin
        quot_next.status     = want.status;
        quot_next.corner     = want.corner;
        quot_next.fuse_valid = want.fuse_valid;
        if (want.status == fcvs_pkg::STATUS_OK)
        begin
            quot_next.vlevel = prod[fcvs_pkg::RECIP_SHIFT +: fcvs_pkg::VLEVEL_W];
        end
        else
        begin
            quot_next.vlevel = '0;
        end
    end

    always_comb
    begin
        result_next.status     = quot_reg.status;
        result_next.vlevel     = quot_reg.vlevel;
        result_next.corner     = quot_reg.corner;
        result_next.fuse_valid = quot_reg.fuse_valid;
        if (quot_reg.status == fcvs_pkg::STATUS_OK)
        begin
            result_next.programmed_uv = fcvs_pkg::UV_W'(quot_reg.vlevel * fcvs_pkg::RAIL_STEP_UV
                                                        + fcvs_pkg::RAIL_MIN_UV);
        end
        else
        begin
            result_next.programmed_uv = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_quot)
        begin
            quot_reg <= quot_next;
        end
        if (ctrl.load_out)
        begin
            result_reg <= result_next;
        end
    end

    assign status        = result_reg.status;
    assign vlevel        = result_reg.vlevel;
    assign programmed_uv = result_reg.programmed_uv;
    assign corner        = result_reg.corner;
    assign fuse_valid    = result_reg.fuse_valid;

endmodule

/* src/fused_corner_voltage_setpoint.sv */
// Top level of the fused corner voltage setpoint block.
// Maps a CPU frequency to a fuse corner, trims that corner's ceiling by the fused
// sign-magnitude steps, clamps to ceiling then floor, adds the undervolt offset
// with a 550 mV hard floor, and encodes a round-up setpoint code for a 375 mV
// plus 12.5 mV per code buck. One item is accepted every clock while in_stall is low;
// each accepted item then passes in order through four register stages: input,
// target voltage, quotient (the reciprocal multiply) and result (the code to
// microvolt multiply). in_stall rises only when all four stages are full and
// out_stall is high. Configuration writes take effect at the next clock.
module fused_corner_voltage_setpoint #(
    parameter int MAX_UNDERVOLT_STEPS = fcvs_pkg::MAX_UNDERVOLT_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fcvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcvs_pkg::FUSE_W-1:0]    cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fcvs_pkg::FREQ_W-1:0]    frequency_mhz,
    input  logic [fcvs_pkg::RANGE_W-1:0]   regulator_range,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [fcvs_pkg::VLEVEL_W-1:0]  vlevel,
    output logic [fcvs_pkg::UV_W-1:0]      programmed_uv,
    output logic [fcvs_pkg::CORNER_W-1:0]  corner,
    output logic                           fuse_valid
);

    fcvs_pkg::cfg_t        cfg;
    fcvs_pkg::item_t       item_reg;
    fcvs_pkg::want_t       want;
    fcvs_pkg::stage_ctrl_t ctrl;
    logic                  load_item;
    logic                  item_valid_reg;
    logic                  want_valid_reg;
    logic                  quot_valid_reg;
    logic                  out_valid_reg;

    // advance a stage when it is empty or the stage after it advances
    assign ctrl.load_out  = !out_valid_reg || !out_stall;
    assign ctrl.load_quot = !quot_valid_reg || ctrl.load_out;
    assign ctrl.load_want = !want_valid_reg || ctrl.load_quot;
    assign load_item      = !item_valid_reg || ctrl.load_want;
    assign in_stall       = !load_item;
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            want_valid_reg <= 1'b0;
            quot_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_item)
            begin
                item_valid_reg <= in_valid;
            end
            if (ctrl.load_want)
            begin
                want_valid_reg <= item_valid_reg;
            end
            if (ctrl.load_quot)
            begin
                quot_valid_reg <= want_valid_reg;
            end
            if (ctrl.load_out)
            begin
                out_valid_reg <= quot_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item && in_valid)
        begin
            item_reg.frequency_mhz   <= frequency_mhz;
            item_reg.regulator_range <= regulator_range;
        end
    end

    fcvs_cfg #(
        .MAX_UNDERVOLT_STEPS(MAX_UNDERVOLT_STEPS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fcvs_want u_want (
        .clk  (clk),
        .load (ctrl.load_want),
        .item (item_reg),
        .cfg  (cfg),
        .want (want)
    );

    fcvs_enc u_enc (
        .clk           (clk),
        .ctrl          (ctrl),
        .want          (want),
        .status        (status),
        .vlevel        (vlevel),
        .programmed_uv (programmed_uv),
        .corner        (corner),
        .fuse_valid    (fuse_valid)
    );

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && want_valid_reg && quot_valid_reg
                      && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline has room");

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> item_valid_reg)
        else $error("accepted item lost at the input stage");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !quot_valid_reg) |=> !out_valid)
        else $error("result repeated after it was taken");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != fcvs_pkg::STATUS_OK)) |-> ((vlevel == '0)
                                                            && (programmed_uv == '0)))
        else $error("nonzero code reported with an error status");

    a_hard_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == fcvs_pkg::STATUS_OK))
            |-> ((programmed_uv >= fcvs_pkg::HARD_FLOOR_UV) && (corner != '0)))
        else $error("programmed voltage below the hard floor or corner missing");
`endif

endmodule
